// File: rtl/hbe_pkg.sv
package hbe_pkg;

  // Sequencer states. The filter states are shared by both lowpass filters.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_F7, ST_F8,
    ST_XMAG,
    ST_DIV,
    ST_S0, ST_S1, ST_S2, ST_S3,
    ST_L1, ST_L2, ST_L3
  } state_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_BASS_G    = 3'd0,
    REG_BASS_A0   = 3'd1,
    REG_HARM_G    = 3'd2,
    REG_HARM_A0   = 3'd3,
    REG_DRIVE     = 3'd4,
    REG_BIAS      = 3'd5,
    REG_HARM_LVL  = 3'd6,
    REG_BASS_LVL  = 3'd7
  } reg_index_t;

  localparam int DIV_STEPS = 24;       // quotient bits of the saturator divide
  localparam int MAG_W     = 41;       // magnitude of the driven bass
  localparam logic [27:0] COEF_MAX = 28'hFFFFFFF;

  // Divider start request.
  typedef struct packed {
    logic               start;
    logic [MAG_W-1:0]   mag;
  } div_req_t;

  // Divider result.
  typedef struct packed {
    logic               done;
    logic [DIV_STEPS-1:0] quot;
  } div_rsp_t;

  // Saturate a 42 bit signed value to 32 bit signed.
  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [41:0] hi;
    logic signed [41:0] lo;
    hi = 42'sd2147483647;
    lo = -42'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// File: rtl/hbe_div.sv
module hbe_div
  import hbe_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  // Restoring division of (mag << 24) by (mag + 2^24), one quotient bit a
  // cycle. The quotient is always below 2^24, so the remainder starts at mag.
  logic [MAG_W:0]         rem;
  logic [MAG_W:0]         dvs;
  logic [DIV_STEPS-1:0]   quot;
  logic [4:0]             cnt;
  logic                   busy;
  logic                   done;
  logic [MAG_W+1:0]       trial;

  assign trial = {rem, 1'b0} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == 5'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= {1'b0, req.mag};
      dvs  <= {1'b0, req.mag} + (42'd1 << 24);
      quot <= '0;
    end else if (busy) begin
      if (!trial[MAG_W+1]) begin
        rem  <= trial[MAG_W:0];
        quot <= {quot[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem  <= {rem[MAG_W-1:0], 1'b0};
        quot <= {quot[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// File: rtl/harmonic_bass_enhancer_unit.sv
// Harmonic bass enhancer.
// Input channel: in_valid / in_stall with left_in and right_in, one stereo
// word per handshake. Output channel: out_valid / out_stall with left_out,
// right_out (copies of the inputs) and lfe_out, the enhanced bass.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while the block is idle.
// One word passes through a bass lowpass, a drive gain, a soft saturator, a
// harmonics lowpass and the LFE mix, all on one shared 29 x 34 bit multiplier
// under a small sequencer, plus a one-bit-a-cycle divider for the saturator.
// A word runs through the bass filter pass, the drive step, the divide, the
// shaping steps, the harmonics filter pass and the mixing steps, in order.
// No new word is taken until the last one is out of the sequencer; in_stall
// is high while a word is being worked on.
// A finished word waits in the output register while the receiver stalls;
// the next input word is still accepted and worked on, and it waits in the
// last sequencer step until the output register is free.
// Synchronous reset clears the filter state and resets the sequencer, out_valid
// and the config registers (not the datapath); no clearing pass is needed.
module harmonic_bass_enhancer_unit
  import hbe_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  output logic signed [SAMPLE_BITS-1:0] lfe_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [24:0]                   cfg_data
);

  localparam int SH_UP  = (SAMPLE_BITS <= 24) ? 24 - SAMPLE_BITS : 0;
  localparam int SH_DN  = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;
  localparam int LFE_SH = 41 - SAMPLE_BITS;
  localparam logic signed [63:0] LFE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] LFE_MIN = -LFE_MAX - 64'sd1;

  // Configuration registers.
  logic [23:0]        bass_g, bass_a0, harm_g, harm_a0;
  logic [23:0]        drive_gain, harmonic_level, bass_level;
  logic signed [24:0] bias_mix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bass_g         <= 24'd0;
      bass_a0        <= 24'd8388608;
      harm_g         <= 24'd0;
      harm_a0        <= 24'd8388608;
      drive_gain     <= 24'd65536;
      bias_mix       <= 25'sd0;
      harmonic_level <= 24'd65536;
      bass_level     <= 24'd65536;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_BASS_G:   bass_g         <= cfg_data[23:0];
        REG_BASS_A0:  bass_a0        <= cfg_data[23:0];
        REG_HARM_G:   harm_g         <= cfg_data[23:0];
        REG_HARM_A0:  harm_a0        <= cfg_data[23:0];
        REG_DRIVE:    drive_gain     <= cfg_data[23:0];
        REG_BIAS:     bias_mix       <= cfg_data;
        REG_HARM_LVL: harmonic_level <= cfg_data[23:0];
        REG_BASS_LVL: bass_level     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  state_t state, state_next;
  logic   fsel;                         // 0: bass filter, 1: harmonics filter

  logic signed [31:0] bass_s1, bass_s2, harm_s1, harm_s2;
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;
  logic signed [33:0] v0, v3;
  logic signed [31:0] v1, v2, bass_v;
  logic [27:0]        a1, a2;
  logic signed [62:0] prod;
  logic signed [63:0] acc;
  logic               neg;
  logic signed [24:0] odd;
  logic [24:0]        even;

  // Shared multiplier operands.
  logic signed [28:0] mul_a;
  logic signed [33:0] mul_b;

  // Selected filter coefficients and state.
  logic [23:0]        g_sel, a0_sel;
  logic signed [31:0] s1_sel, s2_sel;

  assign g_sel  = fsel ? harm_g  : bass_g;
  assign a0_sel = fsel ? harm_a0 : bass_a0;
  assign s1_sel = fsel ? harm_s1 : bass_s1;
  assign s2_sel = fsel ? harm_s2 : bass_s2;

  // Center sample, in Q.24.
  logic signed [33:0] sum_ext, center;
  assign sum_ext = 34'(left_in) + 34'(right_in);
  assign center  = (sum_ext <<< SH_UP) >>> SH_DN;

  // Driven bass and its magnitude for the saturator.
  logic signed [40:0] x_drv;
  logic [MAG_W-1:0]   x_mag;
  assign x_drv = prod[56:16];
  assign x_mag = x_drv[40] ? MAG_W'(-x_drv) : MAG_W'(x_drv);

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign div_req.start = (state == ST_XMAG);
  assign div_req.mag   = x_mag;

  hbe_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic signed [26:0] diff;
  assign diff = 27'(signed'({2'b00, even})) - 27'(odd);

  logic signed [63:0] lfe_sh;
  assign lfe_sh = acc >>> LFE_SH;

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_F0;
        end
      end
      ST_F0: begin
        mul_a = 29'(g_sel);
        mul_b = 34'(a0_sel);
        state_next = ST_F1;
      end
      ST_F1: begin
        mul_a = signed'({4'b0, a0_sel, 1'b0});
        mul_b = 34'(s1_sel);
        state_next = ST_F2;
      end
      ST_F2: begin
        mul_a = signed'({1'b0, a1});
        mul_b = v3;
        state_next = ST_F3;
      end
      ST_F3: begin
        mul_a = 29'(g_sel);
        mul_b = 34'(a1);
        state_next = ST_F4;
      end
      ST_F4: begin
        mul_a = signed'({1'b0, a1});
        mul_b = 34'(s1_sel);
        state_next = ST_F5;
      end
      ST_F5: begin
        mul_a = signed'({1'b0, a2});
        mul_b = v3;
        state_next = ST_F6;
      end
      ST_F6: state_next = ST_F7;
      ST_F7: state_next = ST_F8;
      ST_F8: begin
        mul_a = fsel ? 29'(harmonic_level) : 29'(drive_gain);
        mul_b = 34'(v2);
        state_next = fsel ? ST_L1 : ST_XMAG;
      end
      ST_XMAG: state_next = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_S0;
        end
      end
      ST_S0: begin
        mul_a = 29'(div_rsp.quot);
        mul_b = 34'(div_rsp.quot);
        state_next = ST_S1;
      end
      ST_S1: state_next = ST_S2;
      ST_S2: begin
        mul_a = 29'(bias_mix);
        mul_b = 34'(diff);
        state_next = ST_S3;
      end
      ST_S3: state_next = ST_F0;
      ST_L1: begin
        mul_a = 29'(bass_level);
        mul_b = 34'(bass_v);
        state_next = ST_L2;
      end
      ST_L2: state_next = ST_L3;
      ST_L3: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Product register; every multiplication is consumed in the next step.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bass_s1 <= '0;
      bass_s2 <= '0;
      harm_s1 <= '0;
      harm_s2 <= '0;
      fsel    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: fsel <= 1'b0;
        ST_F7: begin
          if (fsel) begin
            harm_s1 <= sat32(42'(v1) * 42'sd2 - 42'(harm_s1));
          end else begin
            bass_s1 <= sat32(42'(v1) * 42'sd2 - 42'(bass_s1));
          end
        end
        ST_F8: begin
          if (fsel) begin
            harm_s2 <= sat32(42'(v2) * 42'sd2 - 42'(harm_s2));
          end else begin
            bass_s2 <= sat32(42'(v2) * 42'sd2 - 42'(bass_s2));
          end
        end
        ST_S3: fsel <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers of the datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          v0      <= center;
          left_q  <= left_in;
          right_q <= right_in;
        end
      end
      ST_F0: v3 <= v0 - 34'(s2_sel);
      ST_F1: a1 <= (|prod[62:47]) ? COEF_MAX : prod[46:19];
      ST_F2: acc <= 64'(prod);
      ST_F3: acc <= acc + 64'(prod);
      ST_F4: begin
        v1 <= sat32(42'(signed'(acc[63:24])));
        a2 <= (|prod[62:48]) ? COEF_MAX : prod[47:20];
      end
      ST_F5: acc <= 64'(prod);
      ST_F6: acc <= acc + 64'(prod);
      ST_F7: v2 <= sat32(42'(s2_sel) + 42'(signed'(acc[63:24])));
      ST_F8: begin
        if (!fsel) begin
          bass_v <= v2;
        end
      end
      ST_XMAG: neg <= x_drv[40];
      ST_S0: odd <= neg ? -25'(div_rsp.quot) : 25'(div_rsp.quot);
      ST_S1: even <= prod[47:23];
      ST_S3: v0 <= 34'(odd) + 34'(signed'(prod[51:23]));
      ST_L1: acc <= 64'(prod);
      ST_L2: acc <= acc + 64'(prod);
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_L3 && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_L3 && out_free) begin
      left_out  <= left_q;
      right_out <= right_q;
      if (lfe_sh > LFE_MAX) begin
        lfe_out <= LFE_MAX[SAMPLE_BITS-1:0];
      end else if (lfe_sh < LFE_MIN) begin
        lfe_out <= LFE_MIN[SAMPLE_BITS-1:0];
      end else begin
        lfe_out <= lfe_sh[SAMPLE_BITS-1:0];
      end
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted word always starts the bass filter pass.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_F0))
    else $error("accepted word did not start the filter pass");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("divider finished outside its wait state");

  // A new result is only loaded from the final mixing step.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_L3))
    else $error("output loaded outside the final step");
`endif

endmodule
